FILE: rtl/io_traffic_boost_governor_defines.svh
// Assertion macros for the IO traffic boost governor.
// Depends on nothing; included by the top level, which provides clk and arst_n.
`ifndef IO_TRAFFIC_BOOST_GOVERNOR_DEFINES_SVH
`define IO_TRAFFIC_BOOST_GOVERNOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TBG_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("io_traffic_boost_governor assertion failed");
`define TBG_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("io_traffic_boost_governor assertion failed");
`else
`define TBG_ASSERT(label, prop)
`define TBG_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: rtl/io_tbg_pkg.sv
// Types and constants shared by the IO traffic boost governor.
// No dependencies.
package io_tbg_pkg;

	typedef enum logic [1:0] {
		MODE_REQUEST = 2'd0,
		MODE_IDLE    = 2'd1,
		MODE_TIMER   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		DEC_NONE    = 2'd0,
		DEC_LOCK    = 2'd1,
		DEC_RELEASE = 2'd2
	} dec_t;

	typedef enum logic [2:0] {
		CFG_CHUNK_THRESHOLD_KIB    = 3'd0,
		CFG_COUNT_THRESHOLD_BIG    = 3'd1,
		CFG_COUNT_THRESHOLD_LITTLE = 3'd2,
		CFG_PERIOD_BIG_MS          = 3'd3,
		CFG_PERIOD_LITTLE_MS       = 3'd4
	} cfg_index_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned KIB_SHIFT   = 10;
	localparam logic [31:0] NS_PER_MS   = 32'd1000000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] length_bytes;
		logic [62:0] time_ns;
		logic        boot_reset;
	} in_word_t;

	typedef struct packed {
		logic       boost_on;
		logic       boost_changed;
		logic       request_big;
		logic [1:0] decision;
	} out_word_t;

	// periods are held already scaled to nanoseconds
	typedef struct packed {
		logic [14:0] chunk_threshold_kib;
		logic [15:0] count_threshold_big;
		logic [15:0] count_threshold_little;
		logic [31:0] period_big_ns;
		logic [31:0] period_little_ns;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		chunk_threshold_kib:    15'd128,
		count_threshold_big:    16'd40,
		count_threshold_little: 16'd48,
		period_big_ns:          32'd160000000,
		period_little_ns:       32'd3000000
	};

endpackage

FILE: rtl/io_tbg_core.sv
// Governor state and per-word decision logic: classify, window check, count, lock/release.
// Depends on io_tbg_pkg.
module io_tbg_core
	import io_tbg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  in_word_t  word,
	input  cfg_t      cfg,
	output out_word_t result
);

	logic [62:0] window_start_q, window_start_d;
	logic        window_valid_q, window_valid_d;
	logic [62:0] last_request_q, last_request_d;
	logic [15:0] big_count_q, big_count_d;
	logic [15:0] little_count_q, little_count_d;
	logic        locked_q, locked_d;
	logic        held_q, held_d;
	logic        pending_reset_q, pending_reset_d;
	logic        pending_release_q, pending_release_d;

	logic        big;
	logic [63:0] diff_fwd;
	logic [62:0] diff_rev;
	logic [62:0] diff;
	logic [15:0] count_sel;
	logic [15:0] th_sel;
	logic [31:0] period_sel;
	logic        checkpoint;
	dec_t        dec;

	always_comb begin
		big        = {1'b0, word.length_bytes} >=
			{cfg.chunk_threshold_kib, {KIB_SHIFT{1'b0}}};
		diff_fwd   = {1'b0, window_start_q} - {1'b0, last_request_q};
		diff_rev   = last_request_q - window_start_q;
		diff       = diff_fwd[63] ? diff_rev : diff_fwd[62:0];
		count_sel  = big ? big_count_q : little_count_q;
		th_sel     = big ? cfg.count_threshold_big : cfg.count_threshold_little;
		period_sel = big ? cfg.period_big_ns : cfg.period_little_ns;
		checkpoint = diff >= {31'd0, period_sel};

		window_start_d    = window_start_q;
		window_valid_d    = window_valid_q;
		last_request_d    = last_request_q;
		big_count_d       = big_count_q;
		little_count_d    = little_count_q;
		locked_d          = locked_q;
		held_d            = held_q;
		pending_reset_d   = pending_reset_q;
		pending_release_d = pending_release_q;
		dec               = DEC_NONE;

		case (word.mode)
			MODE_REQUEST: begin
				pending_reset_d = 1'b0;
				if (!held_q) begin
					if (!window_valid_q) begin
						window_start_d = word.time_ns;
						last_request_d = word.time_ns;
						window_valid_d = 1'b1;
					end else begin
						last_request_d = word.time_ns;
						if (checkpoint) begin
							big_count_d    = '0;
							little_count_d = '0;
							window_start_d = word.time_ns;
							dec = (({1'b0, count_sel} + 17'd1) >= {1'b0, th_sel}) ?
								DEC_LOCK : DEC_RELEASE;
						end else if (big) begin
							if (big_count_q != 16'hFFFF)
								big_count_d = big_count_q + 16'd1;
						end else begin
							if (little_count_q != 16'hFFFF)
								little_count_d = little_count_q + 16'd1;
						end
					end
				end
			end
			MODE_IDLE: begin
				pending_release_d = !word.boot_reset;
				held_d            = 1'b0;
				pending_reset_d   = 1'b1;
			end
			MODE_TIMER: begin
				if (pending_reset_q) begin
					dec               = pending_release_q ? DEC_RELEASE : DEC_NONE;
					pending_release_d = 1'b0;
					pending_reset_d   = 1'b0;
					window_valid_d    = 1'b0;
					window_start_d    = '0;
					last_request_d    = '0;
					big_count_d       = '0;
					little_count_d    = '0;
				end
			end
			default: begin
			end
		endcase

		case (dec)
			DEC_LOCK: begin
				locked_d = 1'b1;
				held_d   = 1'b1;
			end
			DEC_RELEASE: locked_d = 1'b0;
			default: begin
			end
		endcase

		result.boost_on      = locked_d;
		result.boost_changed = locked_d != locked_q;
		result.request_big   = (word.mode == MODE_REQUEST) && big;
		result.decision      = dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q    <= '0;
			window_valid_q    <= 1'b0;
			last_request_q    <= '0;
			big_count_q       <= '0;
			little_count_q    <= '0;
			locked_q          <= 1'b0;
			held_q            <= 1'b0;
			pending_reset_q   <= 1'b0;
			pending_release_q <= 1'b0;
		end else if (en) begin
			window_start_q    <= window_start_d;
			window_valid_q    <= window_valid_d;
			last_request_q    <= last_request_d;
			big_count_q       <= big_count_d;
			little_count_q    <= little_count_d;
			locked_q          <= locked_d;
			held_q            <= held_d;
			pending_reset_q   <= pending_reset_d;
			pending_release_q <= pending_release_d;
		end
	end

endmodule

FILE: rtl/io_traffic_boost_governor.sv
// IO traffic boost governor top level: config registers, input stage, result register.
// Depends on io_tbg_pkg, io_tbg_core and io_traffic_boost_governor_defines.svh.
//
// Usage: storage events enter on in_word (in_valid/in_stall); one result word per
// event leaves on out_word (out_valid/out_stall). A word moves on a rising edge with
// valid high and stall low.
// Path: an accepted event waits in the input register until the result register is
// free, then passes through the decision logic into the result register, which
// raises out_valid.
// Throughput: one event per cycle while the receiver does not stall.
// While the receiver stalls, the result is held and one more event is taken into
// the input register; after that in_stall is raised.
// Configuration: cfg_we writes cfg_data to register cfg_index (0..4) at the edge;
// periods are scaled to ns on write. Write only while the block is idle.
// Reset: arst_n clears all governor state (boost off, no window) and loads the
// default thresholds and periods; no word is pending afterwards.
`include "io_traffic_boost_governor_defines.svh"
module io_traffic_boost_governor
	import io_tbg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_word
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_word_t  word_s1;
	logic      out_valid_q;
	out_word_t out_word_q;
	out_word_t result;
	logic      res_ready;
	logic      advance;
	logic      in_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHUNK_THRESHOLD_KIB:    cfg_q.chunk_threshold_kib <= cfg_data[14:0];
				CFG_COUNT_THRESHOLD_BIG:    cfg_q.count_threshold_big <= cfg_data;
				CFG_COUNT_THRESHOLD_LITTLE: cfg_q.count_threshold_little <= cfg_data;
				CFG_PERIOD_BIG_MS:
					cfg_q.period_big_ns <= 32'({20'd0, cfg_data[11:0]} * NS_PER_MS);
				CFG_PERIOD_LITTLE_MS:
					cfg_q.period_little_ns <= 32'({20'd0, cfg_data[11:0]} * NS_PER_MS);
				default: begin
				end
			endcase
		end
	end

	assign res_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && res_ready;
	assign in_stall  = valid_s1 && !res_ready;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			word_s1 <= in_word;
	end

	io_tbg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.word   (word_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_word_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`TBG_ASSERT(a_stall_needs_word, in_stall |-> valid_s1)
	`TBG_ASSERT(a_advance_loads_result, advance |=> out_valid)
	`TBG_ASSERT(a_lock_sets_boost, out_valid && (out_word.decision == DEC_LOCK) |-> out_word.boost_on)
	`TBG_ASSERT(a_change_needs_decision, out_valid && out_word.boost_changed |-> (out_word.decision != DEC_NONE))
	`TBG_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid && !in_stall)

endmodule
